>>> sv/rmdu_pkg.sv
// shared types and constants for the multiply/divide unit
`timescale 1ns / 1ps
package rmdu_pkg;

   localparam int XLEN       = 64;
   localparam int HALF       = XLEN / 2;
   localparam int DEST_W     = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index of the machine width control
   localparam int CSR_WIDE_MACHINE = 0;

   typedef enum logic [2:0] {
      OP_MUL    = 3'b000,
      OP_MULH   = 3'b001,
      OP_MULHSU = 3'b010,
      OP_MULHU  = 3'b011,
      OP_DIV    = 3'b100,
      OP_DIVU   = 3'b101,
      OP_REM    = 3'b110,
      OP_REMU   = 3'b111
   } op_type;

   typedef struct packed {
      op_type            op;
      logic              word_mode;
      logic [XLEN-1:0]   first_operand;
      logic [XLEN-1:0]   second_operand;
      logic [DEST_W-1:0] dest_index;
   } req_type;

   typedef struct packed {
      logic [XLEN-1:0]   result_value;
      logic [DEST_W-1:0] result_dest;
   } rsp_type;

endpackage

>>> sv/riscv_mul_div_unit.sv
// pipelined rv64 m-extension multiply/divide unit with rv32 setting
`timescale 1ns / 1ps
// throughput: one transfer per cycle while a held rsp is not refused
// the 64 one-bit restoring divide stages set the depth
// multiplies finish after three stages and ride the same pipe so results stay in order
// a held rsp stalls the whole pipe, bubbles are not squeezed out
// reset: synchronous active high, clears valid bits and sets wide_machine to 1
module riscv_mul_div_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rmdu_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rmdu_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rmdu_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [rmdu_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [rmdu_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import rmdu_pkg::*;

   // per-stage record that walks down the divide pipe
   typedef struct packed {
      op_type            op;
      logic              word;
      logic              mode32;
      logic [DEST_W-1:0] dest;
      logic              an;
      logic              bn;
      logic              bzero;
      logic [XLEN-1:0]   rem;
      logic [XLEN-1:0]   quo;
      logic [XLEN-1:0]   divisor;
      logic [XLEN-1:0]   mres;
   } stage_type;

   // ---------------- configuration ----------------
   logic wide_ff, wide_in;
   logic csr_wr;
   logic csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_WIDE_MACHINE[CSR_ADDR_W-3:0]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wide_in    = (csr_wr && csr_hit) ? csr_pwdata[0] : wide_ff;
   assign csr_prdata = csr_hit ? {{(CSR_DATA_W-1){1'b0}}, wide_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff <= 1'b1;
      end else begin
         wide_ff <= wide_in;
      end
   end

   // ---------------- flow control ----------------
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic adv;
   logic [XLEN:0] vld_ff;

   // whole pipe moves unless the held result is refused
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[XLEN-1:0], req_valid};
      end
   end

   // ---------------- stage 0: operand decode ----------------
   stage_type rec_ff [0:XLEN];
   stage_type rec0_in;
   logic [XLEN-1:0] opa_ff, opb_ff, opa_in, opb_in;
   logic mode32, sgn_a, sgn_b;

   always_comb begin
      mode32 = req_data.word_mode || !wide_ff;
      sgn_a  = (req_data.op == OP_MULH) || (req_data.op == OP_MULHSU) ||
               (req_data.op == OP_DIV)  || (req_data.op == OP_REM);
      sgn_b  = (req_data.op == OP_MULH) || (req_data.op == OP_DIV) ||
               (req_data.op == OP_REM);
      // narrow modes extend to full width; the 64-bit core then gives the right low half
      if (mode32) begin
         opa_in = {{HALF{sgn_a & req_data.first_operand[HALF-1]}},
                   req_data.first_operand[HALF-1:0]};
         opb_in = {{HALF{sgn_b & req_data.second_operand[HALF-1]}},
                   req_data.second_operand[HALF-1:0]};
      end else begin
         opa_in = req_data.first_operand;
         opb_in = req_data.second_operand;
      end
      rec0_in.op      = req_data.op;
      rec0_in.word    = req_data.word_mode;
      rec0_in.mode32  = mode32;
      rec0_in.dest    = req_data.dest_index;
      rec0_in.an      = sgn_a & opa_in[XLEN-1];
      rec0_in.bn      = sgn_b & opb_in[XLEN-1];
      rec0_in.bzero   = (opb_in == '0);
      rec0_in.rem     = '0;
      rec0_in.quo     = rec0_in.an ? (~opa_in + XLEN'(1)) : opa_in;
      rec0_in.divisor = rec0_in.bn ? (~opb_in + XLEN'(1)) : opb_in;
      rec0_in.mres    = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rec_ff[0] <= rec0_in;
         opa_ff    <= opa_in;
         opb_ff    <= opb_in;
      end
   end

   // ---------------- multiply side pipe (stages 1 to 3) ----------------
   logic [XLEN-1:0]   pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [XLEN-1:0]   sub1_ff, sub1_in, sub2_ff;
   logic [2*XLEN-1:0] prod_ff, prod_in;
   logic [XLEN-1:0]   mres_in;
   logic [XLEN-1:0]   hi_s;

   // high-word correction for signed operands
   assign sub1_in = (rec_ff[0].an ? opb_ff : '0) + (rec_ff[0].bn ? opa_ff : '0);

   assign prod_in = {pp_hh_ff, pp_ll_ff}
                  + {{HALF{1'b0}}, pp_lh_ff, {HALF{1'b0}}}
                  + {{HALF{1'b0}}, pp_hl_ff, {HALF{1'b0}}};

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ll_ff <= XLEN'(opa_ff[HALF-1:0]) * XLEN'(opb_ff[HALF-1:0]);
         pp_lh_ff <= XLEN'(opa_ff[HALF-1:0]) * XLEN'(opb_ff[XLEN-1:HALF]);
         pp_hl_ff <= XLEN'(opa_ff[XLEN-1:HALF]) * XLEN'(opb_ff[HALF-1:0]);
         pp_hh_ff <= XLEN'(opa_ff[XLEN-1:HALF]) * XLEN'(opb_ff[XLEN-1:HALF]);
         sub1_ff  <= sub1_in;
         prod_ff  <= prod_in;
         sub2_ff  <= sub1_ff;
      end
   end

   always_comb begin
      hi_s = prod_ff[2*XLEN-1:XLEN] - sub2_ff;
      if (rec_ff[2].op == OP_MUL) begin
         mres_in = prod_ff[XLEN-1:0];
      end else if (rec_ff[2].mode32) begin
         // narrow high multiply: exact product sits in the low word
         mres_in = {{HALF{1'b0}}, prod_ff[XLEN-1:HALF]};
      end else begin
         mres_in = hi_s;
      end
   end

   // ---------------- restoring divide, one quotient bit per stage ----------------
   genvar k;
   generate
      for (k = 1; k <= XLEN; k++) begin : g_div
         logic [XLEN:0]   trial;
         logic            ge;
         stage_type       nxt;
         always_comb begin
            nxt   = rec_ff[k-1];
            trial = {rec_ff[k-1].rem, rec_ff[k-1].quo[XLEN-1]};
            ge    = (trial >= {1'b0, rec_ff[k-1].divisor});
            nxt.rem = ge ? XLEN'(trial - {1'b0, rec_ff[k-1].divisor}) : trial[XLEN-1:0];
            nxt.quo = {rec_ff[k-1].quo[XLEN-2:0], ge};
            if (k == 3) begin
               nxt.mres = mres_in;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               rec_ff[k] <= nxt;
            end
         end
      end
   endgenerate

   // ---------------- final fixup and output register ----------------
   stage_type last;
   logic [XLEN-1:0] q_fix, r_fix, val;
   rsp_type rsp_in;
   logic    rsp_valid_in;

   always_comb begin
      last  = rec_ff[XLEN];
      // divide by zero keeps all ones, no sign fix
      q_fix = (last.bzero || !(last.an ^ last.bn)) ? last.quo : (~last.quo + XLEN'(1));
      r_fix = last.an ? (~last.rem + XLEN'(1)) : last.rem;
      case (last.op)
         OP_DIV, OP_DIVU: val = q_fix;
         OP_REM, OP_REMU: val = r_fix;
         default:         val = last.mres;
      endcase
      if (last.mode32) begin
         if (last.word && ((last.op == OP_MULH) || (last.op == OP_MULHSU) ||
                           (last.op == OP_MULHU))) begin
            val = '0;
         end else begin
            val = {{HALF{val[HALF-1]}}, val[HALF-1:0]};
         end
      end
      rsp_in.result_value = val;
      rsp_in.result_dest  = last.dest;
      rsp_valid_in        = adv ? vld_ff[XLEN] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // ---------------- checks ----------------
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("held result changed");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipe moved while stalled");

   a_last_reaches_out: assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[XLEN] |=> rsp_valid_ff)
      else $error("result lost at output");

endmodule
